// ===== rtl/mie_pkg.sv =====
// Shared types, opcodes and constants of the MIPS32 integer executor.
`timescale 1ns / 1ps
package mie_pkg;

   localparam int DATA_WORDS_DEFAULT = 1024;
   localparam logic [20:0] PROGRAM_WORDS_RESET = 21'd1048576;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // function codes of the special opcode
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   localparam logic [4:0] LINK_REG = 5'd31;

   typedef struct packed {
      logic        start;
      logic        signed_op;
   } div_ctl_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  status;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        hilo_write;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
   } result_type;

endpackage

// ===== rtl/mie_regfile.sv =====
// General register file: 32 words, two registered read ports, one write port.
`timescale 1ns / 1ps
module mie_regfile
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;
   logic        valid_a_ff;
   logic        valid_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_a_ff <= valid_ff[rd_addr_a];
            valid_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = valid_a_ff ? data_a_ff : 32'd0;
   assign rd_data_b = valid_b_ff ? data_b_ff : 32'd0;

endmodule

// ===== rtl/mie_dmem.sv =====
// Data memory: one word-wide port, synchronous read with registered data.
`timescale 1ns / 1ps
module mie_dmem
   import mie_pkg::*;
#(
   parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic                          wr_en,
   input  logic [$clog2(DATA_WORDS)-1:0] addr,
   input  logic [31:0]                   wr_data,
   output logic [31:0]                   rd_data
);

   logic [31:0] mem [DATA_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mie_divider.sv =====
// Iterative restoring divider, one quotient bit a cycle, signed or unsigned.
`timescale 1ns / 1ps
module mie_divider
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] dvs_ff;
   logic        neg_q_ff;
   logic        neg_r_ff;
   logic        neg_a;
   logic        neg_b;
   logic [32:0] rem_shift;
   logic [32:0] diff;

   assign neg_a     = ctl.signed_op & dividend[31];
   assign neg_b     = ctl.signed_op & divisor[31];
   assign rem_shift = {rem_ff, quo_ff[31]};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            rem_ff   <= '0;
            quo_ff   <= neg_a ? 32'd0 - dividend : dividend;
            dvs_ff   <= neg_b ? 32'd0 - divisor : divisor;
            neg_q_ff <= neg_a ^ neg_b;
            neg_r_ff <= neg_a;
         end else if (busy_ff) begin
            // keep the difference when it does not borrow
            if (!diff[32]) begin
               rem_ff <= diff[31:0];
            end else begin
               rem_ff <= rem_shift[31:0];
            end
            quo_ff   <= {quo_ff[30:0], ~diff[32]};
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? 32'd0 - quo_ff : quo_ff;
   assign remainder = neg_r_ff ? 32'd0 - rem_ff : rem_ff;

endmodule

// ===== rtl/mips32_instruction_executor_unit.sv =====
// Top level: sequencer that runs one MIPS32 instruction a beat over the stores.
//
//   channel   ports                       direction   beat
//   req       req_valid/req_ready         in          one instruction word
//   rsp       rsp_valid/rsp_ready         out         one result record
//   csr       csr_write_enable/_data      in          program_words write
//
// ALU ops, jumps and branches go through S_READ and S_WB; multiplies add S_MUL,
// loads and stores S_ADDR and S_MEM. DIV and DIVU wait in S_DIV while the divider
// retires one quotient bit a cycle. A divide by zero goes from S_READ to S_WB, an
// out-of-range PC from S_IDLE to S_WB. If DATA_WORDS is not a power of two, loads
// and stores first wrap the address by reciprocal multiply, fold and one trim.
// Reset clears registers, HI, LO and PC at once; data memory is not cleared.
// A finished result waits in the output register while the next beat enters.
`timescale 1ns / 1ps
module mips32_instruction_executor_unit
   import mie_pkg::*;
#(
   parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic [1:0]  rsp_status,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_hilo_write,
   output logic [31:0] rsp_hi_value,
   output logic [31:0] rsp_lo_value,
   output logic        rsp_mem_write,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_mem_data,
   input  logic        csr_write_enable,
   input  logic [20:0] csr_write_data
);

   localparam int          AW         = $clog2(DATA_WORDS);
   localparam logic [31:0] MEM_BYTES  = 32'(DATA_WORDS * 4);
   localparam logic [31:0] ADDR_MASK  = 32'(DATA_WORDS * 4 - 1);
   localparam bit          IS_POW2    = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
   localparam logic [31:0] WRAP_RECIP = 32'(64'h1_0000_0000 / 64'(DATA_WORDS * 4));

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_DIV,
      S_WRAP,
      S_FOLD,
      S_TRIM,
      S_ADDR,
      S_MEM,
      S_WB
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] instr_ff, instr_in;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;
   logic [20:0] pw_ff, pw_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic [63:0] prod_ff, prod_in;
   result_type  res_ff, res_in;
   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        req_accept;
   logic [31:0] rs_val;
   logic [31:0] rt_val;
   logic        rf_wr_en;
   logic        dm_rd_en;
   logic        dm_wr_en;
   logic [31:0] dm_rd_data;
   logic [31:0] dm_wr_data;
   div_ctl_type div_ctl;
   logic [31:0] div_a;
   logic [31:0] div_b;
   logic        div_done;
   logic [31:0] div_quo;
   logic [31:0] div_rem;

   // decode and execute of the read cycle
   result_type  ex_res;
   state_type   ex_next;
   div_ctl_type ex_div;
   logic [31:0] ex_div_a;
   logic [31:0] ex_div_b;
   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  sa;
   logic [4:0]  rti;
   logic [31:0] imm;
   logic [31:0] simm;
   logic [31:0] pc_plus;
   logic [31:0] ea;
   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;

   // memory stage
   logic [4:0]  byte_sh;
   logic [31:0] word_sh;
   logic [31:0] half_sh;
   logic [31:0] st_mask;
   logic [31:0] hi_corr;

   assign req_accept = req_valid & req_ready;
   assign req_ready  = (state_ff == S_IDLE);

   assign op      = instr_ff[31:26];
   assign fn      = instr_ff[5:0];
   assign sa      = instr_ff[10:6];
   assign rti     = instr_ff[20:16];
   assign imm     = {16'd0, instr_ff[15:0]};
   assign simm    = {{16{instr_ff[15]}}, instr_ff[15:0]};
   assign pc_plus = pc_ff + 32'd1;
   assign ea      = rs_val + simm;

   mie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_a (req_instruction_word[25:21]),
      .rd_addr_b (req_instruction_word[20:16]),
      .rd_data_a (rs_val),
      .rd_data_b (rt_val),
      .wr_en     (rf_wr_en),
      .wr_addr   (res_ff.reg_index),
      .wr_data   (res_ff.reg_value)
   );

   mie_dmem #(
      .DATA_WORDS (DATA_WORDS)
   ) u_dmem (
      .clock   (clock),
      .rd_en   (dm_rd_en),
      .wr_en   (dm_wr_en),
      .addr    (res_ff.mem_address[AW+1:2]),
      .wr_data (dm_wr_data),
      .rd_data (dm_rd_data)
   );

   mie_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      ex_res         = '0;
      ex_res.next_pc = pc_plus;
      ex_res.status  = STATUS_OK;
      ex_next        = S_WB;
      ex_div         = '0;
      ex_div_a       = rs_val;
      ex_div_b       = rt_val;
      wr_en          = 1'b0;
      wr_idx         = instr_ff[15:11];
      wr_val         = '0;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL:  begin wr_en = 1'b1; wr_val = rt_val << sa; end
               FN_SRL:  begin wr_en = 1'b1; wr_val = rt_val >> sa; end
               FN_SRA:  begin wr_en = 1'b1; wr_val = $unsigned($signed(rt_val) >>> sa); end
               FN_SLLV: begin wr_en = 1'b1; wr_val = rt_val << rs_val[4:0]; end
               FN_SRLV: begin wr_en = 1'b1; wr_val = rt_val >> rs_val[4:0]; end
               FN_SRAV: begin
                  wr_en  = 1'b1;
                  wr_val = $unsigned($signed(rt_val) >>> rs_val[4:0]);
               end
               FN_JR:   ex_res.next_pc = rs_val;
               FN_MFHI: begin wr_en = 1'b1; wr_val = hi_ff; end
               FN_MFLO: begin wr_en = 1'b1; wr_val = lo_ff; end
               FN_MULT, FN_MULTU: ex_next = S_MUL;
               FN_DIV, FN_DIVU: begin
                  if (rt_val == 32'd0) begin
                     ex_res.status = STATUS_DIV_ZERO;
                  end else begin
                     ex_div.start     = 1'b1;
                     ex_div.signed_op = (fn == FN_DIV);
                     ex_next          = S_DIV;
                  end
               end
               FN_ADD, FN_ADDU: begin wr_en = 1'b1; wr_val = rs_val + rt_val; end
               FN_SUB, FN_SUBU: begin wr_en = 1'b1; wr_val = rs_val - rt_val; end
               FN_AND:  begin wr_en = 1'b1; wr_val = rs_val & rt_val; end
               FN_OR:   begin wr_en = 1'b1; wr_val = rs_val | rt_val; end
               FN_XOR:  begin wr_en = 1'b1; wr_val = rs_val ^ rt_val; end
               FN_SLT:  begin
                  wr_en  = 1'b1;
                  wr_val = {31'd0, $signed(rs_val) < $signed(rt_val)};
               end
               FN_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, rs_val < rt_val}; end
               default: ex_res.status = STATUS_UNKNOWN;
            endcase
         end
         OP_J: ex_res.next_pc = {6'd0, instr_ff[25:0]};
         OP_JAL: begin
            ex_res.next_pc = {6'd0, instr_ff[25:0]};
            wr_en          = 1'b1;
            wr_idx         = LINK_REG;
            wr_val         = pc_plus;
         end
         OP_BEQ:  if (rs_val == rt_val) ex_res.next_pc = pc_plus + simm;
         OP_BNE:  if (rs_val != rt_val) ex_res.next_pc = pc_plus + simm;
         OP_BLEZ: if ($signed(rs_val) < 32'sd1) ex_res.next_pc = pc_plus + simm;
         OP_BGTZ: if ($signed(rs_val) > 32'sd0) ex_res.next_pc = pc_plus + simm;
         OP_ADDI, OP_ADDIU: begin wr_en = 1'b1; wr_idx = rti; wr_val = rs_val + simm; end
         OP_SLTI: begin
            wr_en  = 1'b1;
            wr_idx = rti;
            wr_val = {31'd0, $signed(rs_val) < $signed(simm)};
         end
         OP_SLTIU: begin wr_en = 1'b1; wr_idx = rti; wr_val = {31'd0, rs_val < simm}; end
         OP_ANDI:  begin wr_en = 1'b1; wr_idx = rti; wr_val = rs_val & imm; end
         OP_ORI:   begin wr_en = 1'b1; wr_idx = rti; wr_val = rs_val | imm; end
         OP_XORI:  begin wr_en = 1'b1; wr_idx = rti; wr_val = rs_val ^ imm; end
         OP_LUI:   begin wr_en = 1'b1; wr_idx = rti; wr_val = {instr_ff[15:0], 16'd0}; end
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
            if (op == OP_SB || op == OP_SH || op == OP_SW) begin
               ex_res.mem_write = 1'b1;
               ex_res.mem_data  = (op == OP_SB) ? {24'd0, rt_val[7:0]} :
                                  (op == OP_SH) ? {16'd0, rt_val[15:0]} : rt_val;
            end else begin
               // value filled in once the word is read
               ex_res.reg_write = (rti != 5'd0);
               ex_res.reg_index = (rti != 5'd0) ? rti : 5'd0;
            end
            if (IS_POW2) begin
               ex_res.mem_address = ea & ADDR_MASK;
               ex_next            = S_ADDR;
            end else begin
               ex_res.mem_address = ea;
               ex_next            = S_WRAP;
            end
         end
         default: ex_res.status = STATUS_UNKNOWN;
      endcase
      if (wr_en && wr_idx != 5'd0) begin
         ex_res.reg_write = 1'b1;
         ex_res.reg_index = wr_idx;
         ex_res.reg_value = wr_val;
      end
   end

   assign byte_sh = {res_ff.mem_address[1:0], 3'b000};
   assign word_sh = dm_rd_data >> byte_sh;
   assign half_sh = dm_rd_data >> {res_ff.mem_address[1], 4'b0000};
   assign st_mask = (op == OP_SB) ? (32'h0000_00FF << byte_sh) :
                    (op == OP_SH) ? (32'h0000_FFFF << {res_ff.mem_address[1], 4'b0000}) :
                    32'hFFFF_FFFF;
   assign dm_wr_data = (dm_rd_data & ~st_mask) |
                       ((op == OP_SB) ? (res_ff.mem_data << byte_sh) :
                        (op == OP_SH) ? (res_ff.mem_data << {res_ff.mem_address[1], 4'b0000}) :
                        res_ff.mem_data);
   // signed multiply: correct the high word of the unsigned product
   assign hi_corr = prod_ff[63:32]
                    - ((fn == FN_MULT && opa_ff[31]) ? opb_ff : 32'd0)
                    - ((fn == FN_MULT && opb_ff[31]) ? opa_ff : 32'd0);

   always_comb begin
      state_in     = state_ff;
      instr_in     = instr_ff;
      pc_in        = pc_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      pw_in        = csr_write_enable ? csr_write_data : pw_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rf_wr_en     = 1'b0;
      dm_rd_en     = 1'b0;
      dm_wr_en     = 1'b0;
      div_ctl      = '0;
      div_a        = ex_div_a;
      div_b        = ex_div_b;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               instr_in = req_instruction_word;
               res_in   = '0;
               if (pc_ff >= {11'd0, pw_ff}) begin
                  res_in.next_pc = pc_ff;
                  res_in.status  = STATUS_RANGE;
                  state_in       = S_WB;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            opa_in   = rs_val;
            opb_in   = rt_val;
            prod_in  = rs_val * rt_val;
            res_in   = ex_res;
            div_ctl  = ex_div;
            state_in = ex_next;
         end
         S_MUL: begin
            res_in.hilo_write = 1'b1;
            res_in.hi_value   = hi_corr;
            res_in.lo_value   = prod_ff[31:0];
            state_in          = S_WB;
         end
         S_DIV: begin
            if (div_done) begin
               res_in.hilo_write = 1'b1;
               res_in.hi_value   = div_rem;
               res_in.lo_value   = div_quo;
               state_in          = S_WB;
            end
         end
         S_WRAP: begin
            // estimate the quotient by the address size, never above the true one
            prod_in  = {32'd0, res_ff.mem_address} * {32'd0, WRAP_RECIP};
            state_in = S_FOLD;
         end
         S_FOLD: begin
            res_in.mem_address = res_ff.mem_address - prod_ff[63:32] * MEM_BYTES;
            state_in           = S_TRIM;
         end
         S_TRIM: begin
            // the estimate may be one short
            if (res_ff.mem_address >= MEM_BYTES) begin
               res_in.mem_address = res_ff.mem_address - MEM_BYTES;
            end
            state_in = S_ADDR;
         end
         S_ADDR: begin
            dm_rd_en = 1'b1;
            state_in = S_MEM;
         end
         S_MEM: begin
            if (res_ff.mem_write) begin
               dm_wr_en = 1'b1;
            end else if (res_ff.reg_write) begin
               case (op)
                  OP_LB:   res_in.reg_value = {{24{word_sh[7]}}, word_sh[7:0]};
                  OP_LBU:  res_in.reg_value = {24'd0, word_sh[7:0]};
                  OP_LH:   res_in.reg_value = {{16{half_sh[15]}}, half_sh[15:0]};
                  OP_LHU:  res_in.reg_value = {16'd0, half_sh[15:0]};
                  default: res_in.reg_value = dm_rd_data;
               endcase
            end
            state_in = S_WB;
         end
         S_WB: begin
            // commit only when the output register is free or being taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               pc_in        = res_ff.next_pc;
               rf_wr_en     = res_ff.reg_write;
               if (res_ff.hilo_write) begin
                  hi_in = res_ff.hi_value;
                  lo_in = res_ff.lo_value;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         pw_ff        <= PROGRAM_WORDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         pw_ff        <= pw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      instr_ff <= instr_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_ff.next_pc;
   assign rsp_status      = rsp_ff.status;
   assign rsp_reg_write   = rsp_ff.reg_write;
   assign rsp_reg_index   = rsp_ff.reg_index;
   assign rsp_reg_value   = rsp_ff.reg_value;
   assign rsp_hilo_write  = rsp_ff.hilo_write;
   assign rsp_hi_value    = rsp_ff.hi_value;
   assign rsp_lo_value    = rsp_ff.lo_value;
   assign rsp_mem_write   = rsp_ff.mem_write;
   assign rsp_mem_address = rsp_ff.mem_address;
   assign rsp_mem_data    = rsp_ff.mem_data;

endmodule

// ===== rtl/mie_checker.sv =====
// Port-level checks of the executor, bound to the top level.
`timescale 1ns / 1ps
module mie_checker
   import mie_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_next_pc,
   input logic [1:0]  rsp_status,
   input logic        rsp_reg_write,
   input logic [4:0]  rsp_reg_index,
   input logic        rsp_hilo_write,
   input logic        rsp_mem_write
);

   // one beat at a time: no second accept straight after the first
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on two cycles running");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
         !rsp_reg_write && !rsp_hilo_write && !rsp_mem_write)
      else $error("out-of-range PC changed state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_reg_index != 5'd0)
      else $error("write to register zero reported");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mem_write || rsp_hilo_write) |-> !rsp_reg_write)
      else $error("store or HI/LO update also wrote a register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled result dropped or changed");

endmodule

bind mips32_instruction_executor_unit mie_checker u_mie_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_next_pc    (rsp_next_pc),
   .rsp_status     (rsp_status),
   .rsp_reg_write  (rsp_reg_write),
   .rsp_reg_index  (rsp_reg_index),
   .rsp_hilo_write (rsp_hilo_write),
   .rsp_mem_write  (rsp_mem_write)
);
